### rtl/core/mcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants of the midpoint circle rasterizer
// Holds the item opcodes, the job control record handed from the front to the
// back through the job queue, and the fixed widths used on both sides.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // Packed RGBA color width
  localparam int COLOR_W = 32;

  // Entries in the job queue between front and back
  localparam int JOB_DEPTH = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } mcr_op_e;

  // Which pixel groups a job emits, and whether the circle ends with it.
  // The diagonal group is always part of a job.
  typedef struct packed {
    logic axis;  // four axis pixels first (x == 0)
    logic oct;   // four octant pixels last (x < y)
    logic done;  // circle finished after this job
  } mcr_job_ctl_t;

endpackage

### rtl/core/mcr_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_job_fifo: job queue between front and back
// Small register queue; the head is shown combinationally to the back.
// ----------------------------------------------------------------------------
module mcr_job_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_wr && do_rd) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("job queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("job queue empty with pointers apart");

endmodule

### rtl/core/mcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_front: item intake and midpoint stepping
// Holds the circle state, loads it on a start, runs one midpoint step per
// step item and pushes a pixel job for any point set to emit.
// ----------------------------------------------------------------------------
module mcr_front
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          op_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  input  logic        [COLOR_W-1:0]     color_i,
  output logic                          job_push_o,
  output mcr_job_ctl_t                  job_ctl_o,
  output logic signed [COORD_BITS-1:0]  job_cx_o,
  output logic signed [COORD_BITS-1:0]  job_cy_o,
  output logic        [RADIUS_BITS:0]   job_x_o,
  output logic        [RADIUS_BITS:0]   job_y_o,
  output logic        [COLOR_W-1:0]     job_color_o
);

  localparam int XY_W  = RADIUS_BITS + 1;
  localparam int DEC_W = RADIUS_BITS + 4;

  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic        [XY_W-1:0]       x_q, x_d, y_q, y_d;
  logic signed [DEC_W-1:0]      dec_q, dec_d;
  logic        [COLOR_W-1:0]    color_q, color_d;
  logic                         active_q, active_d;

  logic        [XY_W-1:0]       x_nx, y_nx;
  logic signed [DEC_W-1:0]      r_ext, dec_init, x_ext, y_ext, dec_step;

  // Start value (5 - 4r) / 4 truncated toward zero: 1, 0, then 2 - r
  assign r_ext    = DEC_W'(signed'({1'b0, radius_i}));
  assign dec_init = (radius_i == '0)                 ? DEC_W'(1) :
                    (radius_i == RADIUS_BITS'(1))    ? '0        :
                                                       DEC_W'(2) - r_ext;

  // One midpoint step
  assign x_nx  = x_q + 1'b1;
  assign y_nx  = dec_q[DEC_W-1] ? y_q : y_q - 1'b1;
  assign x_ext = DEC_W'(signed'({1'b0, x_nx}));
  assign y_ext = DEC_W'(signed'({1'b0, y_nx}));
  assign dec_step = dec_q[DEC_W-1] ? DEC_W'(dec_q + 2 * x_ext + 1)
                                   : DEC_W'(dec_q + 2 * (x_ext - y_ext) + 1);

  always_comb begin
    cx_d       = cx_q;
    cy_d       = cy_q;
    x_d        = x_q;
    y_d        = y_q;
    dec_d      = dec_q;
    color_d    = color_q;
    active_d   = active_q;
    job_push_o = 1'b0;
    job_ctl_o  = '{axis: 1'b0, oct: 1'b0, done: 1'b0};
    if (accept_i) begin
      if (mcr_op_e'(op_i) == OP_START) begin
        // Load a new circle, dropping any running one
        cx_d       = center_x_i;
        cy_d       = center_y_i;
        color_d    = color_i;
        x_d        = '0;
        y_d        = {1'b0, radius_i};
        dec_d      = dec_init;
        active_d   = (radius_i != '0);
        job_push_o = 1'b1;
        job_ctl_o  = '{axis: 1'b1, oct: (radius_i != '0), done: (radius_i == '0)};
      end else if (active_q) begin
        x_d        = x_nx;
        y_d        = y_nx;
        dec_d      = dec_step;
        active_d   = (x_nx < y_nx);
        // Crossing the diagonal ends the circle with no pixels
        job_push_o = (x_nx <= y_nx);
        job_ctl_o  = '{axis: 1'b0, oct: (x_nx < y_nx), done: !(x_nx < y_nx)};
      end
    end
  end

  assign job_cx_o    = cx_d;
  assign job_cy_o    = cy_d;
  assign job_x_o     = x_d;
  assign job_y_o     = y_d;
  assign job_color_o = color_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

  a_active_below_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (x_q < y_q))
    else $error("circle active on or past the diagonal");

endmodule

### rtl/core/mcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_back: pixel emitter
// Walks the pixel slots of the head job into the result register, one
// pixel per cycle while the receiver takes pixels.
// ----------------------------------------------------------------------------
module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  mcr_job_ctl_t                  head_ctl_i,
  input  logic signed [COORD_BITS-1:0]  head_cx_i,
  input  logic signed [COORD_BITS-1:0]  head_cy_i,
  input  logic        [RADIUS_BITS:0]   head_x_i,
  input  logic        [RADIUS_BITS:0]   head_y_i,
  input  logic        [COLOR_W-1:0]     head_color_i,
  output logic                          head_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output logic signed [COORD_BITS:0]    pixel_x_o,
  output logic signed [COORD_BITS:0]    pixel_y_o,
  output logic        [COLOR_W-1:0]     pixel_color_o,
  output logic                          last_of_run_o,
  output logic                          circle_done_o
);

  localparam int XY_W  = RADIUS_BITS + 1;
  localparam int PIX_W = COORD_BITS + 1;
  localparam int SUM_W = ((COORD_BITS > XY_W) ? COORD_BITS : XY_W) + 2;

  typedef enum logic [1:0] {
    GRP_AXIS = 2'd0,
    GRP_DIAG = 2'd1,
    GRP_OCT  = 2'd2
  } grp_e;

  localparam logic [1:0] SUB_LAST = 2'd3;

  logic [3:0]              cnt_q;
  logic [3:0]              slot;
  grp_e                    grp;
  logic [1:0]              sub;
  logic                    load, is_last;
  logic                    col_neg, row_neg;
  logic [XY_W-1:0]         col_mag, row_mag;
  logic signed [SUM_W-1:0] col_off, row_off, col_sum, row_sum;
  logic                    out_valid_q;

  // Jobs without the axis group start at the diagonal slots
  assign slot = cnt_q + (head_ctl_i.axis ? 4'd0 : 4'd4);
  assign grp  = grp_e'(slot[3:2]);
  assign sub  = slot[1:0];

  assign is_last = (sub == SUB_LAST) &&
                   ((grp == GRP_OCT) || ((grp == GRP_DIAG) && !head_ctl_i.oct));
  assign load       = head_valid_i && (!out_valid_q || pop);
  assign head_pop_o = load && is_last;

  always_comb begin
    col_neg = 1'b0;
    row_neg = 1'b0;
    col_mag = '0;
    row_mag = '0;
    unique case (grp)
      GRP_AXIS: begin
        if (sub[1]) begin
          col_mag = head_y_i;
          col_neg = sub[0];
        end else begin
          row_mag = head_y_i;
          row_neg = sub[0];
        end
      end
      GRP_DIAG: begin
        col_mag = head_x_i;
        row_mag = head_y_i;
        col_neg = sub[0];
        row_neg = sub[1];
      end
      GRP_OCT: begin
        col_mag = head_y_i;
        row_mag = head_x_i;
        col_neg = sub[0];
        row_neg = sub[1];
      end
      default: begin
      end
    endcase
  end

  assign col_off = col_neg ? -SUM_W'(signed'({1'b0, col_mag}))
                           :  SUM_W'(signed'({1'b0, col_mag}));
  assign row_off = row_neg ? -SUM_W'(signed'({1'b0, row_mag}))
                           :  SUM_W'(signed'({1'b0, row_mag}));
  assign col_sum = SUM_W'(head_cx_i) + col_off;
  assign row_sum = SUM_W'(head_cy_i) + row_off;

  // Result register: refill on the same edge the receiver takes a pixel
  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_x_o     <= col_sum[PIX_W-1:0];
      pixel_y_o     <= row_sum[PIX_W-1:0];
      pixel_color_o <= head_color_i;
      last_of_run_o <= is_last;
      circle_done_o <= head_ctl_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cnt_q       <= is_last ? '0 : cnt_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty = !out_valid_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (slot <= 4'd11))
    else $error("pixel slot beyond last octant pixel");

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |=> (cnt_q == '0))
    else $error("slot counter not rewound after last pixel");

endmodule

### rtl/core/midpoint_circle_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit: midpoint circle outline generator
// Eight-way symmetric outline pixels, one pixel per cycle while the
// receiver takes them, from start and step items.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): a beat is taken when push is high and full low.
//   op_i = start loads center, radius and color and emits the first point
//   set; op_i = step advances the circle by one midpoint step. A step while
//   no circle runs is taken and produces nothing.
//   Result queue (empty/pop): the oldest pixel sits on the result ports while
//   empty is low and leaves on a beat with pop high. last_of_run_o marks the
//   final pixel of an item, circle_done_o the pixels of the finishing item.
// Pipeline and throughput:
//   An item passes the job queue and the result register: the front steps
//   combinationally and writes the job queue on the beat edge, and the
//   emitter loads the result register from the queue head once it is free.
//   The emitter writes one pixel per cycle while the receiver takes pixels;
//   a step item yields 4 or 8 pixels (none when it crosses the diagonal or
//   no circle runs), a start 12 (8 at radius 0). The front takes a beat
//   every cycle while the two-entry job queue has room.
// Reset clears the circle state (idle), the job queue and the result
// valid flag. A stalled receiver holds the current pixel; the emitter and
// then the job queue fill, and full rises once both queue entries are taken.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          op_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  input  logic        [7:0]             red_i,
  input  logic        [7:0]             green_i,
  input  logic        [7:0]             blue_i,
  input  logic        [7:0]             alpha_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_BITS:0]    pixel_x_o,
  output logic signed [COORD_BITS:0]    pixel_y_o,
  output logic        [COLOR_W-1:0]     pixel_color_o,
  output logic                          last_of_run_o,
  output logic                          circle_done_o
);

  localparam int XY_W  = RADIUS_BITS + 1;
  localparam int CTL_W = $bits(mcr_job_ctl_t);
  localparam int JOB_W = CTL_W + 2 * COORD_BITS + 2 * XY_W + COLOR_W;

  logic                         accept;
  logic [COLOR_W-1:0]           color;

  // Front to queue
  logic                         job_push;
  mcr_job_ctl_t                 job_ctl;
  logic signed [COORD_BITS-1:0] job_cx, job_cy;
  logic        [XY_W-1:0]       job_x, job_y;
  logic        [COLOR_W-1:0]    job_color;
  logic        [JOB_W-1:0]      job_wdata, job_rdata;

  // Queue to back
  logic                         head_valid, head_pop;
  mcr_job_ctl_t                 head_ctl;
  logic signed [COORD_BITS-1:0] head_cx, head_cy;
  logic        [XY_W-1:0]       head_x, head_y;
  logic        [COLOR_W-1:0]    head_color;

  // Take an item whenever the job queue has room
  assign accept = push && !full;
  assign color  = {red_i, green_i, blue_i, alpha_i};

  mcr_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .color_i    (color),
    .job_push_o (job_push),
    .job_ctl_o  (job_ctl),
    .job_cx_o   (job_cx),
    .job_cy_o   (job_cy),
    .job_x_o    (job_x),
    .job_y_o    (job_y),
    .job_color_o(job_color)
  );

  assign job_wdata = {job_ctl, job_cx, job_cy, job_x, job_y, job_color};

  // Pack/unpack the job record around the queue
  mcr_job_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (job_push),
    .wdata_i(job_wdata),
    .full_o (full),
    .rd_i   (head_pop),
    .valid_o(head_valid),
    .rdata_o(job_rdata)
  );

  assign {head_ctl, head_cx, head_cy, head_x, head_y, head_color} = job_rdata;

  mcr_back #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ctl_i   (head_ctl),
    .head_cx_i    (head_cx),
    .head_cy_i    (head_cy),
    .head_x_i     (head_x),
    .head_y_i     (head_y),
    .head_color_i (head_color),
    .head_pop_o   (head_pop),
    .pop          (pop),
    .empty        (empty),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .last_of_run_o(last_of_run_o),
    .circle_done_o(circle_done_o)
  );

endmodule
